/* rtl/core/deq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: operation and status
// codes, the result record and the default capacity.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DATA_W       = 32;
	localparam int DEF_CAPACITY = 32;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_LIST       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		status_t           status;
		logic              last;
	} result_t;

endpackage

/* rtl/core/double_ended_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit words held in one synchronous
// slot RAM; push and pop at either end, and list of the whole contents.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                          Contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser  tdata: value; tuser: op
// m_*       out  m_tvalid m_tready m_tdata m_tuser  tdata: result_value;
//                m_tlast                            tuser: status; tlast: last
//
// One request is worked at a time. Push and any rejected or unknown request
// pass through EXEC; a pop goes on to POP (registered RAM read), a list to
// LIST (one RAM read per element, streamed back to back while the output has
// room). A held output record does not stop a new request from being taken;
// a stalled m_tready stalls the sequencer only when it has a result to hand
// off. Reset clears head and count; the slot RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
	import deq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_W-1:0]    s_tdata,   // [31:0] value
	input  logic [2:0]           s_tuser,   // [2:0] op
	// result channel
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_W-1:0]    m_tdata,   // [31:0] result_value
	output logic [1:0]           m_tuser,   // [1:0] status
	output logic                 m_tlast
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic              out_valid_q;
	result_t           out_q;
	logic              emit_ok;
	logic              res_valid;
	result_t           res;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	// The output register can take a new record when it is empty or is
	// being drained in this cycle.
	assign emit_ok = !out_valid_q || m_tready;

	deq_ctrl #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_op    (op_t'(s_tuser)),
		.req_value (s_tdata),
		.emit_ok   (emit_ok),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	deq_ram #(
		.DEPTH  (CAPACITY),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: load a new record, otherwise drop the held one once
	// the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.value;
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

`ifndef SYNTHESIS
	// A record is produced only when the output register has room for it.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || m_tready))
		else $error("result produced while output register is blocked");

	// The sequencer never accepts a request and emits a result together.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res_valid)
		else $error("result produced while idle");

	// A taken request keeps the request channel closed in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request accepted while one is in flight");

	// Slot RAM is never read and written in the same cycle.
	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("slot RAM read and write collide");
`endif

endmodule

/* rtl/core/deq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Slot store of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module deq_ram
	import deq_pkg::*;
#(
	parameter int DEPTH  = DEF_CAPACITY,
	parameter int ADDR_W = $clog2(DEF_CAPACITY)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/deq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: holds head and count, drives the slot store and
// produces result records, one request at a time, when the output has room.
// ----------------------------------------------------------------------------
module deq_ctrl
	import deq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int IDX_W    = $clog2(DEF_CAPACITY),
	parameter int CNT_W    = $clog2(DEF_CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  op_t               req_op,
	input  logic [DATA_W-1:0] req_value,
	input  logic              emit_ok,
	output logic              res_valid,
	output result_t           res,
	output logic              ram_we,
	output logic [IDX_W-1:0]  ram_waddr,
	output logic [DATA_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [IDX_W-1:0]  ram_raddr,
	input  logic [DATA_W-1:0] ram_rdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_POP  = 4'b0100,
		S_LIST = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	op_t               op_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              full, empty;
	logic [IDX_W-1:0]  head_dec;
	logic [IDX_W-1:0]  idx_nxt;
	logic              list_last;

	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
	                                              input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(CAPACITY)) begin
			s = s - (IDX_W+1)'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign head_dec  = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
	assign idx_nxt   = idx_q + IDX_W'(1);
	assign list_last = ({{(CNT_W-IDX_W){1'b0}}, idx_q} + CNT_W'(1) == count_q);
	assign req_ready = (state_q == S_IDLE);
	assign ram_wdata = val_q;

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		idx_d      = idx_q;
		res_valid  = 1'b0;
		res.value  = '0;
		res.status = STAT_OK;
		res.last   = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = head_q;
		ram_re     = 1'b0;
		ram_raddr  = head_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						if (emit_ok) begin
							res_valid = 1'b1;
							state_d   = S_IDLE;
							if (full) begin
								res.status = STAT_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
								if (op_q == OP_PUSH_FRONT) begin
									ram_waddr = head_dec;
									head_d    = head_dec;
								end else begin
									ram_waddr = ring_add(head_q, count_q[IDX_W-1:0]);
								end
							end
						end
					end
					OP_POP_FRONT, OP_POP_BACK: begin
						if (empty) begin
							if (emit_ok) begin
								res_valid  = 1'b1;
								res.status = STAT_EMPTY;
								state_d    = S_IDLE;
							end
						end else begin
							ram_re  = 1'b1;
							count_d = count_q - CNT_W'(1);
							state_d = S_POP;
							if (op_q == OP_POP_FRONT) begin
								head_d = ring_add(head_q, IDX_W'(1));
							end else begin
								ram_raddr = ring_add(head_q, count_d[IDX_W-1:0]);
							end
						end
					end
					OP_LIST: begin
						if (empty) begin
							if (emit_ok) begin
								res_valid  = 1'b1;
								res.status = STAT_EMPTY;
								state_d    = S_IDLE;
							end
						end else begin
							ram_re  = 1'b1;
							idx_d   = '0;
							state_d = S_LIST;
						end
					end
					default: begin
						if (emit_ok) begin
							res_valid = 1'b1;
							state_d   = S_IDLE;
						end
					end
				endcase
			end
			S_POP: begin
				if (emit_ok) begin
					res_valid = 1'b1;
					res.value = ram_rdata;
					state_d   = S_IDLE;
				end
			end
			S_LIST: begin
				if (emit_ok) begin
					res_valid = 1'b1;
					res.value = ram_rdata;
					res.last  = list_last;
					if (list_last) begin
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = ring_add(head_q, idx_nxt);
						idx_d     = idx_nxt;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q  <= req_op;
			val_q <= req_value;
		end
	end

endmodule

/* tb/sv/double_ended_queue_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Self-checking bench for the double-ended queue: a short table of directed
// requests, then random fill and drain runs that reach full and empty at both
// ends. Every result is checked against a behavioral queue copy or a typed
// row's own result, under several patterns of sender gaps and back-pressure.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;
	import deq_pkg::*;

	localparam int DEPTH        = DEF_CAPACITY;
	localparam int RANDOM_COUNT = 270;
	localparam int ROW_COUNT    = 20;

	// op codes the block does not define; each must be ignored with one ok result
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;

	// one directed request; typed rows carry their single expected result
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] word;
		logic        typed;
		result_t     outcome;
	} stim_row_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;
	logic [2:0]        s_tuser  = OP_PUSH_FRONT;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [1:0]        m_tuser;
	logic              m_tlast;

	// behavioral copy of the queue
	logic [31:0] ring_words [DEPTH];
	int          ring_front = 0;
	int          ring_fill  = 0;

	result_t     step_results [$];
	result_t     awaited_results [$];
	stim_row_t   directed_rows [ROW_COUNT];

	int sender_idle_pct = 0;
	int sink_stall_pct  = 0;
	int mismatches      = 0;
	int requests_sent   = 0;
	int results_checked = 0;
	int full_refusals   = 0;
	int empty_refusals  = 0;
	int list_requests   = 0;
	int peak_fill       = 0;

	double_ended_queue_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] value
		.s_tuser  (s_tuser),   // [2:0] op
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] result_value
		.m_tuser  (m_tuser),   // [1:0] status
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run: every request a full list with
	// the receiver stalling most cycles still ends far sooner than this.
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic log_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic result_t make_result(input logic [31:0] word, input status_t st,
			input logic fin);
		result_t r;
		r.value  = word;
		r.status = st;
		r.last   = fin;
		return r;
	endfunction

	// Work out the results of one request and advance the queue copy.
	task automatic predict_deque_results(input logic [2:0] op, input logic [31:0] word);
		int pos;
		step_results.delete();
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (ring_fill >= DEPTH) begin
					step_results.push_back(make_result('0, STAT_FULL, 1'b1));
					full_refusals++;
				end else begin
					if (op == OP_PUSH_FRONT) begin
						ring_front = (ring_front + DEPTH - 1) % DEPTH;
						ring_words[ring_front] = word;
					end else begin
						ring_words[(ring_front + ring_fill) % DEPTH] = word;
					end
					ring_fill++;
					if (ring_fill > peak_fill) begin
						peak_fill = ring_fill;
					end
					step_results.push_back(make_result('0, STAT_OK, 1'b1));
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (ring_fill == 0) begin
					step_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
					empty_refusals++;
				end else if (op == OP_POP_FRONT) begin
					step_results.push_back(make_result(ring_words[ring_front], STAT_OK, 1'b1));
					ring_front = (ring_front + 1) % DEPTH;
					ring_fill--;
				end else begin
					pos = (ring_front + ring_fill - 1) % DEPTH;
					step_results.push_back(make_result(ring_words[pos], STAT_OK, 1'b1));
					ring_fill--;
				end
			end
			OP_LIST: begin
				list_requests++;
				if (ring_fill == 0) begin
					step_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
				end else begin
					for (int i = 0; i < ring_fill; i++) begin
						pos = (ring_front + i) % DEPTH;
						step_results.push_back(make_result(ring_words[pos], STAT_OK,
							i == ring_fill - 1));
					end
				end
			end
			default: begin
				step_results.push_back(make_result('0, STAT_OK, 1'b1));
			end
		endcase
	endtask

	// Offer one request, hold it until taken, then record what it must produce.
	task automatic send_request(input logic [2:0] op, input logic [31:0] word,
			input logic typed, input result_t outcome);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		predict_deque_results(op, word);
		if (typed) begin
			awaited_results.push_back(outcome);
		end else begin
			foreach (step_results[i]) awaited_results.push_back(step_results[i]);
		end
		requests_sent++;
	endtask

	task automatic set_pressure(input int phase);
		case (phase)
			0: begin
				sender_idle_pct = 0;
				sink_stall_pct  = 0;
			end
			1: begin
				sender_idle_pct = 57;
				sink_stall_pct  = 0;
			end
			2: begin
				sender_idle_pct = 0;
				sink_stall_pct  = 57;
			end
			default: begin
				sender_idle_pct = 27;
				sink_stall_pct  = 27;
			end
		endcase
	endtask

	// Favor the edge words so sign and carry bits toggle often.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Receiver: stall at random according to the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Result checker: compare each handed-off result with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				log_mismatch("result with nothing expected, value", m_tdata, '0);
			end else begin
				want = awaited_results.pop_front();
				if (m_tdata !== want.value) begin
					log_mismatch("result_value", m_tdata, want.value);
				end
				if (m_tuser !== want.status) begin
					log_mismatch("status", 32'(m_tuser), 32'(want.status));
				end
				if (m_tlast !== want.last) begin
					log_mismatch("last", 32'(m_tlast), 32'(want.last));
				end
				results_checked++;
			end
		end
	end

	initial begin
		logic [2:0]  op;
		logic        filling;
		int          pick;
		result_t     none;

		none = make_result('0, STAT_OK, 1'b0);
		// Directed part: empty refusals, spare op codes, extreme words pushed at both
		// ends (the first front push wraps the head below slot zero), then unwind.
		directed_rows = '{
			'{OP_LIST,       32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 1'b1}},
			'{OP_POP_FRONT,  32'h1234_5678, 1'b1, '{32'h0, STAT_EMPTY, 1'b1}},
			'{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_EMPTY, 1'b1}},
			'{OP_SPARE_A,    32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_OK,    1'b1}},
			'{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{32'h0, STAT_OK,    1'b1}},
			'{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0, STAT_OK,    1'b1}},
			'{OP_PUSH_BACK,  32'h0000_0000, 1'b1, '{32'h0, STAT_OK,    1'b1}},
			'{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_OK,    1'b1}},
			'{OP_LIST,       32'h0000_0000, 1'b0, none},
			'{OP_SPARE_B,    32'h5555_5555, 1'b1, '{32'h0, STAT_OK,    1'b1}},
			'{OP_SPARE_C,    32'hAAAA_AAAA, 1'b1, '{32'h0, STAT_OK,    1'b1}},
			'{OP_POP_FRONT,  32'h0000_0000, 1'b0, none},
			'{OP_POP_BACK,   32'h0000_0000, 1'b0, none},
			'{OP_LIST,       32'hFFFF_FFFF, 1'b0, none},
			'{OP_POP_BACK,   32'h0000_0000, 1'b0, none},
			'{OP_POP_FRONT,  32'h0000_0000, 1'b0, none},
			'{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 1'b1}},
			'{OP_PUSH_FRONT, 32'h0000_0001, 1'b1, '{32'h0, STAT_OK,    1'b1}},
			'{OP_POP_BACK,   32'h0000_0000, 1'b0, none},
			'{OP_LIST,       32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 1'b1}}
		};

		// Hold reset, then release it on an edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pressure(0);
		foreach (directed_rows[r]) begin
			send_request(directed_rows[r].op, directed_rows[r].word, directed_rows[r].typed,
				directed_rows[r].outcome);
		end

		// Random part: alternate fill-biased and drain-biased runs so the queue hits
		// full and empty repeatedly, wrapping the ring at both ends.
		filling = 1'b1;
		for (int k = 0; k < RANDOM_COUNT; k++) begin
			set_pressure((k / 45) % 4);
			pick = $urandom_range(99);
			if (pick < 75) begin
				if (filling) begin
					op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
				end else begin
					op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
				end
			end else if (pick < 85) begin
				if (filling) begin
					op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
				end else begin
					op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
				end
			end else if (pick < 95) begin
				op = OP_LIST;
			end else begin
				op = 3'($urandom_range(OP_SPARE_C, OP_SPARE_A));
			end
			send_request(op, pick_word(), 1'b0, none);
			// linger at the extremes a little so refusals get exercised
			if (filling && ring_fill == DEPTH && $urandom_range(3) == 0) begin
				filling = 1'b0;
			end else if (!filling && ring_fill == 0 && $urandom_range(3) == 0) begin
				filling = 1'b1;
			end
		end
		s_tvalid <= 1'b0;
		set_pressure(0);

		// Drain, then give the block time to show any stray result.
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (48) @(posedge clk);

		$display("Covered %0d requests and %0d results; %0d lists, peak fill %0d of %0d.",
			requests_sent, results_checked, list_requests, peak_fill, DEPTH);
		$display("Refused %0d pushes on a full queue and %0d pops on an empty one.",
			full_refusals, empty_refusals);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_queue_unit.sv
tb/sv/double_ended_queue_unit_tb.sv
